// ===== rtl/two_level_page_translator_with_tlb_defines.svh =====
// Assertion macros for the page translator.
// Both expect a clock named clk in scope; PGX_ASSERT also expects an active-low reset named arst_n.
`ifndef TWO_LEVEL_PAGE_TRANSLATOR_WITH_TLB_DEFINES_SVH
`define TWO_LEVEL_PAGE_TRANSLATOR_WITH_TLB_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define PGX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define PGX_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PGX_ASSERT(lbl, prop, msg)
`define PGX_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// ===== rtl/pgxlat_pkg.sv =====
package pgxlat_pkg;

	// table sizes
	localparam int SEG_ENTRIES  = 2048;
	localparam int PAGE_ENTRIES = 4096;
	localparam int TLB_SLOTS    = 8;
	localparam int SEG_AW       = $clog2(SEG_ENTRIES);
	localparam int PAGE_AW      = $clog2(PAGE_ENTRIES);
	localparam int TLB_IW       = $clog2(TLB_SLOTS);

	// address layout
	localparam int VA_W   = 32;
	localparam int OFS_W  = 12;
	localparam int VPN_W  = VA_W - OFS_W;
	localparam int SX_LSB = 20;
	localparam int SX_W   = 11;
	localparam int PX_W   = 8;

	// field widths
	localparam int ACT_W = 2;
	localparam int IDX_W = 12;
	localparam int ORG_W = 12;
	localparam int CNT_W = 12;
	localparam int ST_W  = 2;
	localparam int PTE_W = ORG_W + 1;

	// stream widths, padded to whole bytes
	localparam int IN_BITS  = ACT_W + VA_W + IDX_W + ORG_W + VA_W + 2;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = ST_W + VA_W + 2;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// action codes
	localparam logic [ACT_W-1:0] ACT_XLATE   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SEG_WR  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PAGE_WR = 2'd2;

	// status codes
	localparam logic [ST_W-1:0] ST_OK         = 2'd0;
	localparam logic [ST_W-1:0] ST_SEG_FAULT  = 2'd1;
	localparam logic [ST_W-1:0] ST_PAGE_FAULT = 2'd2;

	// request item, last field in the low bits
	typedef struct packed {
		logic             entry_protect;
		logic             entry_invalid;
		logic [VA_W-1:0]  frame_address;
		logic [ORG_W-1:0] origin_value;
		logic [IDX_W-1:0] entry_index;
		logic [VA_W-1:0]  virtual_address;
		logic [ACT_W-1:0] action;
	} item_t;

	// result item, last field in the low bits
	typedef struct packed {
		logic            tlb_hit;
		logic            write_protected;
		logic [VA_W-1:0] physical_address;
		logic [ST_W-1:0] status;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic look;
		logic walk;
		logic push;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic in_xlate;
		logic look_done;
	} sts_t;

endpackage

// ===== rtl/pgxlat_dp.sv =====
module pgxlat_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pgxlat_pkg::cmd_t              cmd,
	output pgxlat_pkg::sts_t              sts,
	input  logic [pgxlat_pkg::IN_W-1:0]   s_tdata,
	output logic [pgxlat_pkg::OUT_W-1:0]  m_tdata,
	input  logic                          cfg_valid,
	input  logic [pgxlat_pkg::CNT_W-1:0]  cfg_data
);
	import pgxlat_pkg::*;

	typedef struct packed {
		logic             invalid;
		logic [ORG_W-1:0] origin;
	} seg_word_t;

	typedef struct packed {
		logic            invalid;
		logic            protect;
		logic [VA_W-1:0] frame;
	} page_word_t;

	item_t              item;
	logic [CNT_W-1:0]   seg_count_q;
	logic [VA_W-1:0]    va_q;
	logic [PAGE_AW:0]   clr_q;

	seg_word_t          seg_mem [SEG_ENTRIES];
	seg_word_t          seg_rd_q;
	logic               seg_we;
	logic [SEG_AW-1:0]  seg_wa;
	seg_word_t          seg_wd;

	page_word_t         page_mem [PAGE_ENTRIES];
	page_word_t         page_rd_q;
	logic               pte_oob_q;
	logic               page_we;
	logic [PAGE_AW-1:0] page_wa;
	page_word_t         page_wd;
	logic [PTE_W-1:0]   pte_sum;

	logic               tlb_valid_q [TLB_SLOTS];
	logic [VPN_W-1:0]   tlb_vpn_q   [TLB_SLOTS];
	logic [VPN_W-1:0]   tlb_rpn_q   [TLB_SLOTS];
	logic               tlb_prot_q  [TLB_SLOTS];

	logic [TLB_IW-1:0]  slot;
	logic [VPN_W-1:0]   vpn;
	logic [SX_W-1:0]    sx;
	logic [PX_W-1:0]    px;
	logic               tlb_hit;
	logic               seg_fault;
	logic               walk_ok;
	logic [VA_W-1:0]    walk_pa;

	res_t               res_q;
	logic [OUT_W-1:0]   out_q;

	assign item = item_t'(s_tdata[IN_BITS-1:0]);

	// segment count register, written any time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= '0;
		end else if (cfg_valid) begin
			seg_count_q <= cfg_data;
		end
	end

	// clearing sweep over both table stores after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear && !sts.clear_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign sts.clear_done = (clr_q == (PAGE_AW + 1)'(PAGE_ENTRIES));
	assign sts.in_xlate   = (item.action == ACT_XLATE);

	// latch the address of a request
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			va_q <= item.virtual_address;
		end
	end

	// segment store write port: sweep or table load
	always_comb begin
		seg_we = 1'b0;
		seg_wa = item.entry_index[SEG_AW-1:0];
		seg_wd = '{invalid: item.entry_invalid, origin: item.origin_value};
		if (cmd.clear) begin
			seg_we = !sts.clear_done && (clr_q < (PAGE_AW + 1)'(SEG_ENTRIES));
			seg_wa = clr_q[SEG_AW-1:0];
			seg_wd = '{invalid: 1'b1, origin: '0};
		end else if (cmd.accept && item.action == ACT_SEG_WR) begin
			seg_we = ({1'b0, item.entry_index} < (IDX_W + 1)'(SEG_ENTRIES));
		end
	end

	// segment store: read at the segment index when a request is taken
	always_ff @(posedge clk) begin
		if (seg_we) begin
			seg_mem[seg_wa] <= seg_wd;
		end
		if (cmd.accept) begin
			seg_rd_q <= seg_mem[item.virtual_address[SX_LSB +: SEG_AW]];
		end
	end

	// page store write port: sweep or table load
	always_comb begin
		page_we = 1'b0;
		page_wa = item.entry_index[PAGE_AW-1:0];
		page_wd = '{invalid: item.entry_invalid, protect: item.entry_protect,
			frame: item.frame_address};
		if (cmd.clear) begin
			page_we = !sts.clear_done;
			page_wa = clr_q[PAGE_AW-1:0];
			page_wd = '{invalid: 1'b1, protect: 1'b0, frame: '0};
		end else if (cmd.accept && item.action == ACT_PAGE_WR) begin
			page_we = ({1'b0, item.entry_index} < (IDX_W + 1)'(PAGE_ENTRIES));
		end
	end

	// address fields of the latched request
	assign vpn  = va_q[VA_W-1:OFS_W];
	assign slot = va_q[OFS_W +: TLB_IW];
	assign sx   = va_q[SX_LSB +: SX_W];
	assign px   = va_q[OFS_W +: PX_W];

	// page table entry number from the segment entry
	assign pte_sum = {1'b0, seg_rd_q.origin} + {{(PTE_W - PX_W){1'b0}}, px};

	// page store: read during the lookup cycle
	always_ff @(posedge clk) begin
		if (page_we) begin
			page_mem[page_wa] <= page_wd;
		end
		if (cmd.look) begin
			page_rd_q <= page_mem[pte_sum[PAGE_AW-1:0]];
			pte_oob_q <= (pte_sum >= PTE_W'(PAGE_ENTRIES));
		end
	end

	// TLB compare and segment checks
	assign tlb_hit   = tlb_valid_q[slot] && (tlb_vpn_q[slot] == vpn);
	assign seg_fault = ({{(CNT_W - SX_W){1'b0}}, sx} >= seg_count_q) || seg_rd_q.invalid;
	assign sts.look_done = tlb_hit || seg_fault;

	// walk outcome
	assign walk_ok = !pte_oob_q && !page_rd_q.invalid;
	assign walk_pa = page_rd_q.frame + {{(VA_W - OFS_W){1'b0}}, va_q[OFS_W-1:0]};

	// TLB valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TLB_SLOTS; i++) begin
				tlb_valid_q[i] <= 1'b0;
			end
		end else if (cmd.walk && walk_ok) begin
			tlb_valid_q[slot] <= 1'b1;
		end
	end

	// TLB refill after a good walk
	always_ff @(posedge clk) begin
		if (cmd.walk && walk_ok) begin
			tlb_vpn_q[slot]  <= vpn;
			tlb_rpn_q[slot]  <= walk_pa[VA_W-1:OFS_W];
			tlb_prot_q[slot] <= page_rd_q.protect;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_q <= '{tlb_hit: 1'b0, write_protected: 1'b0, physical_address: '0,
				status: ST_OK};
		end else if (cmd.look) begin
			if (tlb_hit) begin
				res_q <= '{tlb_hit: 1'b1, write_protected: tlb_prot_q[slot],
					physical_address: {tlb_rpn_q[slot], va_q[OFS_W-1:0]}, status: ST_OK};
			end else begin
				res_q <= '{tlb_hit: 1'b0, write_protected: 1'b0, physical_address: '0,
					status: ST_SEG_FAULT};
			end
		end else if (cmd.walk) begin
			if (walk_ok) begin
				res_q <= '{tlb_hit: 1'b0, write_protected: page_rd_q.protect,
					physical_address: walk_pa, status: ST_OK};
			end else begin
				res_q <= '{tlb_hit: 1'b0, write_protected: 1'b0, physical_address: '0,
					status: ST_PAGE_FAULT};
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q <= {{(OUT_W - OUT_BITS){1'b0}}, res_q};
		end
	end

	assign m_tdata = out_q;

endmodule

// ===== rtl/pgxlat_ctrl.sv =====
module pgxlat_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output pgxlat_pkg::cmd_t cmd,
	input  pgxlat_pkg::sts_t sts
);
	import pgxlat_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_WALK,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;

	// commands follow the state
	always_comb begin
		cmd.clear  = (state_q == S_CLEAR);
		cmd.accept = (state_q == S_IDLE) && s_tvalid;
		cmd.look   = (state_q == S_LOOK);
		cmd.walk   = (state_q == S_WALK);
		cmd.push   = (state_q == S_HOLD) && (!m_tvalid_q || m_tready);
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clear_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= sts.in_xlate ? S_LOOK : S_HOLD;
					end
				end
				S_LOOK: begin
					state_q <= sts.look_done ? S_HOLD : S_WALK;
				end
				S_WALK: begin
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (cmd.push) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

endmodule

// ===== rtl/two_level_page_translator_with_tlb.sv =====
// Two-level virtual address translator with an 8-slot direct-mapped TLB.
// After reset the block sweeps both table stores to invalid, one entry per
// cycle, and takes no request until the sweep is done; the segment count
// register can be written meanwhile. A request (translate, segment entry
// load or page entry load) returns exactly one result. A table load goes
// from idle straight to hold; TLB hits and segment faults go through lookup;
// a TLB miss that reads the page table also goes through walk, since the
// segment entry and then the page entry come from registered memory reads
// one after the other. The output register lets a new request start while
// the previous result waits. Table loads do not purge the TLB.
`include "two_level_page_translator_with_tlb_defines.svh"

module two_level_page_translator_with_tlb (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// action, virtual_address, entry_index, origin_value, frame_address,
	// entry_invalid, entry_protect
	input  logic [pgxlat_pkg::IN_W-1:0]   s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status, physical_address, write_protected, tlb_hit
	output logic [pgxlat_pkg::OUT_W-1:0]  m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pgxlat_pkg::CNT_W-1:0]  cfg_data
);
	import pgxlat_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	pgxlat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	pgxlat_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data)
	);

	// checks
	`PGX_ASSERT(a_ready_after_clear, s_tready |-> sts.clear_done, "request taken during clear")
	`PGX_ASSERT(a_push_slot_free, cmd.push |-> (!m_tvalid || m_tready), "result overwritten")
	`PGX_ASSERT(a_push_shows, cmd.push |=> m_tvalid, "pushed result not presented")
	`PGX_ASSERT(a_hit_is_ok, (m_tvalid && m_tdata[35]) |-> (m_tdata[1:0] == ST_OK), "hit with fault")
	`PGX_ASSERT_NR(a_quiet_in_reset, !arst_n |=> (!m_tvalid && !s_tready), "active in reset")

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	import pgxlat_pkg::*;

	// action code the block takes but does nothing with
	localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic s_tvalid = 1'b0;
	logic s_tready;
	// action, virtual_address, entry_index, origin_value, frame_address,
	// entry_invalid, entry_protect
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// status, physical_address, write_protected, tlb_hit
	logic [OUT_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	two_level_page_translator_with_tlb DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// requests waiting to be offered, and results owed by the block
	item_t pending_requests[$];
	res_t expected_results[$];

	int unsigned send_idle_pct = 9;
	int unsigned recv_idle_pct = 81;
	logic recv_hold = 1'b0;
	event hold_off_ev;
	int mismatch_count = 0;
	int results_checked = 0;

	// shadow of the translator state
	logic [CNT_W-1:0] seg_limit;
	logic tlb_ok [TLB_SLOTS];
	logic [VPN_W-1:0] tlb_vpage [TLB_SLOTS];
	logic [VPN_W-1:0] tlb_rpage [TLB_SLOTS];
	logic tlb_wp [TLB_SLOTS];
	logic [ORG_W-1:0] seg_origin [SEG_ENTRIES];
	logic seg_bad [SEG_ENTRIES];
	logic [VA_W-1:0] page_frame [PAGE_ENTRIES];
	logic page_bad [PAGE_ENTRIES];
	logic page_wp [PAGE_ENTRIES];

	// stimulus bookkeeping: last origin loaded per segment, recent pages
	logic [ORG_W-1:0] gen_origin [SEG_ENTRIES];
	logic [VPN_W-1:0] recent_vpns[$];

	// result of one request; updates the shadow tables and TLB
	function automatic res_t translate_or_load(input item_t req);
		res_t r;
		logic [VPN_W-1:0] vpn;
		logic [TLB_IW-1:0] slot;
		logic [OFS_W-1:0] ofs;
		logic [SX_W-1:0] sx;
		logic [PX_W-1:0] px;
		logic [PTE_W-1:0] pte;
		logic [VA_W-1:0] pa;
		r = '0;
		if (req.action == ACT_XLATE) begin
			vpn = req.virtual_address[VA_W-1:OFS_W];
			slot = vpn[TLB_IW-1:0];
			ofs = req.virtual_address[OFS_W-1:0];
			sx = req.virtual_address[SX_LSB +: SX_W];
			px = req.virtual_address[OFS_W +: PX_W];
			if (tlb_ok[slot] && tlb_vpage[slot] == vpn) begin
				r.status = ST_OK;
				r.physical_address = {tlb_rpage[slot], ofs};
				r.write_protected = tlb_wp[slot];
				r.tlb_hit = 1'b1;
			end else if ({1'b0, sx} >= seg_limit || seg_bad[sx]) begin
				r.status = ST_SEG_FAULT;
			end else begin
				// origin plus page index may run past the page store
				pte = PTE_W'(seg_origin[sx]) + PTE_W'(px);
				if (pte >= PAGE_ENTRIES || page_bad[pte[PAGE_AW-1:0]]) begin
					r.status = ST_PAGE_FAULT;
				end else begin
					pa = page_frame[pte[PAGE_AW-1:0]] + VA_W'(ofs);
					tlb_ok[slot] = 1'b1;
					tlb_vpage[slot] = vpn;
					tlb_rpage[slot] = pa[VA_W-1:OFS_W];
					tlb_wp[slot] = page_wp[pte[PAGE_AW-1:0]];
					r.status = ST_OK;
					r.physical_address = pa;
					r.write_protected = page_wp[pte[PAGE_AW-1:0]];
				end
			end
		end else if (req.action == ACT_SEG_WR) begin
			// out-of-range index is dropped, status still ok
			if (req.entry_index < SEG_ENTRIES) begin
				seg_origin[req.entry_index[SEG_AW-1:0]] = req.origin_value;
				seg_bad[req.entry_index[SEG_AW-1:0]] = req.entry_invalid;
			end
		end else if (req.action == ACT_PAGE_WR) begin
			if (req.entry_index < PAGE_ENTRIES) begin
				page_frame[req.entry_index[PAGE_AW-1:0]] = req.frame_address;
				page_bad[req.entry_index[PAGE_AW-1:0]] = req.entry_invalid;
				page_wp[req.entry_index[PAGE_AW-1:0]] = req.entry_protect;
			end
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		mismatch_count++;
		$display("MISMATCH %s at result %0d: got 0x%0h, want 0x%0h",
			what, results_checked, got, want);
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		if (expected_results.size() == 0) begin
			flag_mismatch("result with no request pending", OUT_W'(got), '0);
			return;
		end
		want = expected_results.pop_front();
		if (got.status !== want.status)
			flag_mismatch("status", OUT_W'(got.status), OUT_W'(want.status));
		if (got.physical_address !== want.physical_address)
			flag_mismatch("physical_address", OUT_W'(got.physical_address),
				OUT_W'(want.physical_address));
		if (got.write_protected !== want.write_protected)
			flag_mismatch("write_protected", OUT_W'(got.write_protected),
				OUT_W'(want.write_protected));
		if (got.tlb_hit !== want.tlb_hit)
			flag_mismatch("tlb_hit", OUT_W'(got.tlb_hit), OUT_W'(want.tlb_hit));
		results_checked++;
	endtask

	// request builders; fields the action ignores carry random bits
	function automatic item_t random_item(input logic [ACT_W-1:0] act);
		item_t it;
		it.action = act;
		it.virtual_address = $urandom;
		it.entry_index = IDX_W'($urandom);
		it.origin_value = ORG_W'($urandom);
		it.frame_address = $urandom;
		it.entry_invalid = 1'($urandom);
		it.entry_protect = 1'($urandom);
		return it;
	endfunction

	task automatic queue_translate(input logic [VA_W-1:0] va);
		item_t it;
		it = random_item(ACT_XLATE);
		it.virtual_address = va;
		pending_requests.push_back(it);
		recent_vpns.push_back(va[VA_W-1:OFS_W]);
		if (recent_vpns.size() > 16)
			void'(recent_vpns.pop_front());
	endtask

	task automatic queue_seg_load(input logic [IDX_W-1:0] idx, input logic [ORG_W-1:0] org,
			input logic inv);
		item_t it;
		it = random_item(ACT_SEG_WR);
		it.entry_index = idx;
		it.origin_value = org;
		it.entry_invalid = inv;
		pending_requests.push_back(it);
		if (idx < SEG_ENTRIES)
			gen_origin[idx[SEG_AW-1:0]] = org;
	endtask

	task automatic queue_page_load(input logic [IDX_W-1:0] idx, input logic [VA_W-1:0] frame,
			input logic inv, input logic prot);
		item_t it;
		it = random_item(ACT_PAGE_WR);
		it.entry_index = idx;
		it.frame_address = frame;
		it.entry_invalid = inv;
		it.entry_protect = prot;
		pending_requests.push_back(it);
	endtask

	// mostly translations mixed with table loads; many translations aim at loaded pages
	task automatic queue_random_phase(input int count, input int sx_span);
		int roll;
		logic [SX_W-1:0] sx;
		logic [PX_W-1:0] px;
		logic [ORG_W-1:0] org;
		item_t noise;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			sx = ($urandom_range(9) != 0) ? SX_W'($urandom_range(sx_span - 1)) : SX_W'($urandom);
			px = ($urandom_range(3) != 0) ? PX_W'($urandom_range(7)) : PX_W'($urandom);
			if (roll < 12) begin
				// a few origins near the top so the walk runs off the store
				org = ($urandom_range(9) == 0) ? ORG_W'($urandom_range(4095, 4080))
					: ORG_W'($urandom);
				queue_seg_load(IDX_W'(sx), org, $urandom_range(7) == 0);
			end else if (roll < 35) begin
				queue_page_load(gen_origin[sx] + IDX_W'(px), $urandom,
					$urandom_range(7) == 0, 1'($urandom_range(1)));
			end else if (roll < 60 && recent_vpns.size() != 0) begin
				queue_translate({recent_vpns[$urandom_range(recent_vpns.size() - 1)],
					OFS_W'($urandom)});
			end else if (roll < 80) begin
				queue_translate({1'($urandom), sx, px, OFS_W'($urandom)});
			end else if (roll < 95) begin
				queue_translate($urandom);
			end else begin
				// unused action, or segment load past the table
				noise = random_item(($urandom_range(1) != 0) ? ACT_NOP : ACT_SEG_WR);
				noise.entry_index[IDX_W-1] = 1'b1;
				pending_requests.push_back(noise);
			end
		end
	endtask

	task automatic write_seg_limit(input logic [CNT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		seg_limit = value;
	endtask

	task automatic wait_for_drain();
		do @(negedge clk);
		while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// request driver; the result is predicted when the request is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(translate_or_load(item_t'(s_tdata[IN_BITS-1:0])));
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= IN_W'(pending_requests.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(res_t'(m_tdata[OUT_BITS-1:0]));
			m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// long receiver stall so the block backs up into its input
	always @(hold_off_ev) begin
		recv_hold <= 1'b1;
		repeat (400) @(posedge clk);
		recv_hold <= 1'b0;
	end

	// run limit
	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

	// stimulus sequence
	initial begin
		seg_limit = '0;
		for (int i = 0; i < TLB_SLOTS; i++) begin
			tlb_ok[i] = 1'b0;
			tlb_vpage[i] = '0;
			tlb_rpage[i] = '0;
			tlb_wp[i] = 1'b0;
		end
		for (int i = 0; i < SEG_ENTRIES; i++) begin
			seg_origin[i] = '0;
			seg_bad[i] = 1'b1;
			gen_origin[i] = '0;
		end
		for (int i = 0; i < PAGE_ENTRIES; i++) begin
			page_frame[i] = '0;
			page_bad[i] = 1'b1;
			page_wp[i] = 1'b0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: full segment range
		write_seg_limit(12'(SEG_ENTRIES));
		@(negedge clk);
		queue_translate(32'h0000_0000);                // invalid segment
		queue_seg_load(12'd0, 12'd0, 1'b0);
		queue_seg_load(12'd1, 12'd0, 1'b0);
		queue_translate(32'h0000_0123);                // invalid page
		queue_page_load(12'd0, 32'hFFFF_F000, 1'b0, 1'b1);
		queue_translate(32'h0000_0FFF);                // walk, top of address space
		queue_translate(32'h0000_0ABC);                // TLB hit
		queue_translate(32'h8000_0ABC);                // bit 31 differs: miss, refill
		queue_page_load(12'd0, 32'h0000_1800, 1'b0, 1'b0);
		queue_translate(32'h8000_0001);                // stale hit, loads do not purge
		queue_translate(32'h0000_0FFF);                // unaligned frame, carry into page
		queue_seg_load(12'd2047, 12'd4095, 1'b0);
		queue_page_load(12'd4095, 32'h1234_5000, 1'b0, 1'b0);
		queue_translate(32'h7FF0_0000);                // last segment, last page entry
		queue_translate(32'h7FF0_1000);                // page index past the store
		queue_translate(32'hFFFF_FFFF);
		queue_seg_load(12'hFFF, 12'd5, 1'b0);          // past the segment table
		queue_seg_load(12'd2048, 12'd5, 1'b0);
		pending_requests.push_back(random_item(ACT_NOP));
		queue_seg_load(12'd2047, 12'd4095, 1'b1);
		queue_translate(32'h7FF0_0ABC);                // hit although segment now invalid
		queue_translate(32'h7FF0_8000);                // same slot, miss, segment fault
		queue_page_load(12'd1, 32'hABCD_E000, 1'b1, 1'b1);
		queue_translate(32'h0000_1000);                // invalidated page
		wait_for_drain();

		// one segment only; receiver stalls for a long stretch
		write_seg_limit(12'd1);
		@(negedge clk);
		queue_translate(32'h0010_0000);                // valid segment beyond the count
		queue_random_phase(250, 2);
		->hold_off_ev;
		wait_for_drain();

		// sender idles more than the receiver
		write_seg_limit(12'(SEG_ENTRIES));
		@(negedge clk);
		send_idle_pct = 81;
		recv_idle_pct = 9;
		queue_random_phase(260, 16);
		wait_for_drain();

		// no idling from here on
		write_seg_limit(12'hFFF);
		@(negedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_phase(260, 16);
		wait_for_drain();

		write_seg_limit(12'($urandom_range(2047, 2)));
		@(negedge clk);
		queue_random_phase(300, 24);
		wait_for_drain();

		// every TLB miss faults, only TLB hits translate
		write_seg_limit(12'd0);
		@(negedge clk);
		queue_random_phase(180, 16);
		wait_for_drain();

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
